// File: src/assert_macros.svh
// Assertion macros shared by the camera controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NOW(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NOW(label, clk, rst_n, cond)
`endif
`endif

// File: src/ypc_pkg.sv
// Package with types, constants and tables of the camera controller.
package ypc_pkg;
	localparam int TabLen = 24;
	localparam logic signed [33:0] Deg360 = 34'sd23592960;
	localparam logic signed [33:0] Deg270 = 34'sd17694720;
	localparam logic signed [33:0] Deg180 = 34'sd11796480;
	localparam logic signed [33:0] Deg90 = 34'sd5898240;
	localparam logic signed [31:0] Deg2RadQ32 = 32'sd74961321;
	localparam logic signed [33:0] GainQ30 = 34'sd652032874;
	// Whole degrees of a yaw sum are biased by a multiple of 360 to be non-negative, then
	// divided by 360 with a reciprocal multiply and a 27-bit shift.
	localparam logic [17:0] WrapBias = 18'd65880;
	localparam logic [18:0] WrapRecip = 19'd372828;
	localparam logic [2:0] CMD_MOUSE = 3'd0;
	localparam logic [2:0] CMD_FWD = 3'd1;
	localparam logic [2:0] CMD_BACK = 3'd2;
	localparam logic [2:0] CMD_RIGHT = 3'd3;
	localparam logic [2:0] CMD_LEFT = 3'd4;
	localparam logic [1:0] REG_SPEED = 2'd0;
	localparam logic [1:0] REG_SENS = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	typedef struct packed {
		logic [2:0] command;
		logic signed [31:0] pointer_x;
		logic signed [31:0] pointer_y;
		logic [19:0] time_step;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic [24:0] yaw_out;
		logic signed [23:0] pitch_out;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic signed [33:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic signed [15:0] sin_q14;
		logic signed [15:0] cos_q14;
	} cordic_rsp_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		unique case (i)
			5'd0: atan_q30 = 34'sd843314857;
			5'd1: atan_q30 = 34'sd497837829;
			5'd2: atan_q30 = 34'sd263043837;
			5'd3: atan_q30 = 34'sd133525159;
			5'd4: atan_q30 = 34'sd67021687;
			5'd5: atan_q30 = 34'sd33543516;
			5'd6: atan_q30 = 34'sd16775851;
			5'd7: atan_q30 = 34'sd8388437;
			5'd8: atan_q30 = 34'sd4194283;
			5'd9: atan_q30 = 34'sd2097149;
			5'd10: atan_q30 = 34'sd1048576;
			5'd11: atan_q30 = 34'sd524288;
			5'd12: atan_q30 = 34'sd262144;
			5'd13: atan_q30 = 34'sd131072;
			5'd14: atan_q30 = 34'sd65536;
			5'd15: atan_q30 = 34'sd32768;
			5'd16: atan_q30 = 34'sd16384;
			5'd17: atan_q30 = 34'sd8192;
			5'd18: atan_q30 = 34'sd4096;
			5'd19: atan_q30 = 34'sd2048;
			5'd20: atan_q30 = 34'sd1024;
			5'd21: atan_q30 = 34'sd512;
			5'd22: atan_q30 = 34'sd256;
			5'd23: atan_q30 = 34'sd128;
			default: atan_q30 = 34'sd0;
		endcase
	endfunction

	function automatic logic signed [15:0] clamp_unit(input logic signed [35:0] v);
		if (v > 36'sd16384) begin
			clamp_unit = 16'sd16384;
		end else if (v < -36'sd16384) begin
			clamp_unit = -16'sd16384;
		end else begin
			clamp_unit = v[15:0];
		end
	endfunction
endpackage

// File: src/ypc_cordic.sv
// Iterative CORDIC unit giving sine and cosine in Q2.14 of an angle in degrees.
module ypc_cordic #(
	parameter int Steps = 16
) (
	input logic clk,
	input logic arst_n,
	input ypc_pkg::cordic_req_t req,
	output ypc_pkg::cordic_rsp_t rsp
);
	import ypc_pkg::*;

	localparam int IterW = $clog2(Steps + 1);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_CONV = 3'b010,
		C_ROT = 3'b100
	} cstate_t;

	cstate_t state_q;
	logic done_q;
	logic [IterW-1:0] iter_q;
	logic signed [63:0] prod_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic signed [33:0] dx, dy, at;
	logic signed [63:0] zr;
	logic signed [35:0] sr, cr;

	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign at = atan_q30(5'(iter_q));
	assign zr = (prod_q + 64'sd131072) >>> 18;
	assign sr = (36'(y_q) + 36'sd32768) >>> 16;
	assign cr = (36'(x_q) + 36'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						state_q <= C_CONV;
					end
				end
				C_CONV: state_q <= C_ROT;
				C_ROT: begin
					if (iter_q == IterW'(Steps - 1)) begin
						state_q <= C_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: prod_q <= 64'(req.angle) * 64'(Deg2RadQ32);
			C_CONV: begin
				z_q <= zr[33:0];
				x_q <= GainQ30;
				y_q <= '0;
				iter_q <= '0;
			end
			C_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				iter_q <= iter_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.sin_q14 = clamp_unit(sr);
	assign rsp.cos_q14 = clamp_unit(cr);
endmodule

// File: src/ypc_core.sv
// Sequencer and datapath holding the camera state and running each request.
module ypc_core #(
	parameter int CordicSteps = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ypc_pkg::req_t req,
	input logic [23:0] move_speed,
	input logic [15:0] look_sensitivity,
	input logic [22:0] pitch_limit,
	output logic done,
	output ypc_pkg::rsp_t rsp
);
	import ypc_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_SCALE = 12'b000000000010,
		S_ANG = 12'b000000000100,
		S_YAW = 12'b000000001000,
		S_WRAP = 12'b000000010000,
		S_MOD = 12'b000000100000,
		S_PITCH = 12'b000001000000,
		S_CYAW = 12'b000010000000,
		S_CPIT = 12'b000100000000,
		S_FRONT = 12'b001000000000,
		S_MOVE = 12'b010000000000,
		S_DONE = 12'b100000000000
	} state_t;

	state_t state_q;
	req_t req_q;
	logic signed [31:0] pos_q [3];
	logic signed [33:0] yaw_q, pitch_q;
	logic signed [15:0] front_q [3];
	logic signed [31:0] lastx_q, lasty_q;
	logic first_q;
	logic signed [47:0] scale_q;
	logic signed [15:0] sy_q, cy_q;
	logic [1:0] k_q;
	logic signed [33:0] dyaw_q, dpit_q;
	logic signed [33:0] ysum_q;
	logic [8:0] wq_q;
	logic negq_q;

	cordic_req_t creq;
	cordic_rsp_t crsp;

	ypc_cordic #(.Steps(CordicSteps)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp)
	);

	logic signed [32:0] xo, yo;
	logic signed [50:0] pxs, pys;
	logic signed [33:0] pnew, lim;
	logic [17:0] aoff;
	logic [36:0] qprod;
	logic [17:0] rem;
	logic signed [35:0] yfold;
	logic signed [15:0] comp, sgnsin, sgncos;
	logic signed [64:0] mprod;
	logic signed [50:0] d;
	logic signed [32:0] psum;
	logic signed [31:0] mvx, mvy;
	logic signed [44:0] sprod;
	logic signed [31:0] fprod;

	always_comb begin
		mvx = first_q ? req_q.pointer_x : lastx_q;
		mvy = first_q ? req_q.pointer_y : lasty_q;
		xo = 33'(req_q.pointer_x) - 33'(mvx);
		yo = 33'(mvy) - 33'(req_q.pointer_y);
		pxs = (51'(xo) * $signed({1'b0, look_sensitivity}) + 51'sd32768) >>> 16;
		pys = (51'(yo) * $signed({1'b0, look_sensitivity}) + 51'sd32768) >>> 16;
		aoff = ysum_q[33:16] + WrapBias;
		qprod = 37'(aoff) * 37'(WrapRecip);
		rem = aoff - (18'({wq_q, 8'b0}) + 18'({wq_q, 6'b0}) + 18'({wq_q, 5'b0})
			+ 18'({wq_q, 3'b0}));
		if (36'(yaw_q) >= 36'(Deg270)) begin
			yfold = 36'(yaw_q) - 36'(Deg360);
		end else if (36'(yaw_q) > 36'(Deg90)) begin
			yfold = 36'(yaw_q) - 36'(Deg180);
		end else begin
			yfold = 36'(yaw_q);
		end
		lim = (34'(pitch_limit) > Deg90) ? Deg90 : 34'(pitch_limit);
		pnew = pitch_q + dpit_q;
		if (pnew > lim) begin
			pnew = lim;
		end else if (pnew < -lim) begin
			pnew = -lim;
		end
		sgnsin = negq_q ? -crsp.sin_q14 : crsp.sin_q14;
		sgncos = negq_q ? -crsp.cos_q14 : crsp.cos_q14;
		priority case (1'b1)
			(req_q.command == CMD_FWD || req_q.command == CMD_BACK): comp = front_q[k_q];
			k_q == 2'd0: comp = -sy_q;
			k_q == 2'd1: comp = '0;
			default: comp = cy_q;
		endcase
		mprod = 65'(scale_q) * 65'(comp);
		d = 51'((mprod + 65'sd8192) >>> 14);
		if (req_q.command == CMD_BACK || req_q.command == CMD_LEFT) begin
			d = -d;
		end
		psum = 33'(pos_q[k_q]) + 33'(d[32:0]);
		if (d > 51'sd4294967295 || psum > 33'sd2147483647) begin
			psum = 33'sd2147483647;
		end else if (d < -51'sd4294967296 || psum < -33'sd2147483648) begin
			psum = -33'sd2147483648;
		end
		sprod = 45'({1'b0, req_q.time_step}) * 45'({1'b0, move_speed});
		fprod = 32'(sy_q) * 32'(crsp.cos_q14);
	end

	always_comb begin
		creq.start = 1'b0;
		creq.angle = yfold[33:0];
		if (state_q == S_PITCH) begin
			creq.start = 1'b1;
		end else if (state_q == S_CYAW && crsp.done && req_q.command == CMD_MOUSE) begin
			creq.start = 1'b1;
			creq.angle = pitch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= 32'sd196608;
			yaw_q <= Deg270;
			pitch_q <= '0;
			front_q[0] <= '0;
			front_q[1] <= '0;
			front_q[2] <= -16'sd16384;
			first_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_SCALE;
				S_SCALE: begin
					priority case (1'b1)
						req_q.command == CMD_MOUSE: state_q <= S_ANG;
						(req_q.command == CMD_FWD || req_q.command == CMD_BACK):
							state_q <= S_MOVE;
						(req_q.command == CMD_RIGHT || req_q.command == CMD_LEFT):
							state_q <= S_PITCH;
						default: state_q <= S_DONE;
					endcase
				end
				S_ANG: begin
					first_q <= 1'b0;
					state_q <= S_YAW;
				end
				S_YAW: begin
					pitch_q <= pnew;
					state_q <= S_WRAP;
				end
				S_WRAP: state_q <= S_MOD;
				S_MOD: begin
					yaw_q <= {9'd0, rem[8:0], ysum_q[15:0]};
					state_q <= S_PITCH;
				end
				S_PITCH: state_q <= S_CYAW;
				S_CYAW: begin
					if (crsp.done) begin
						state_q <= (req_q.command == CMD_MOUSE) ? S_CPIT : S_MOVE;
					end
				end
				S_CPIT: begin
					if (crsp.done) begin
						front_q[1] <= crsp.sin_q14;
						front_q[2] <= clamp_unit(36'((fprod + 32'sd8192) >>> 14));
						state_q <= S_FRONT;
					end
				end
				S_FRONT: begin
					front_q[0] <= clamp_unit(36'((32'(cy_q) * 32'(sgncos) + 32'sd8192) >>> 14));
					state_q <= S_DONE;
				end
				S_MOVE: begin
					pos_q[k_q] <= psum[31:0];
					if (k_q == 2'd2) state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		if (state_q == S_SCALE) begin
			scale_q <= 48'((sprod + 45'sd32768) >>> 16);
			k_q <= '0;
		end
		if (state_q == S_ANG) begin
			lastx_q <= req_q.pointer_x;
			lasty_q <= req_q.pointer_y;
			dyaw_q <= pxs[33:0];
			dpit_q <= pys[33:0];
		end
		if (state_q == S_YAW) begin
			ysum_q <= yaw_q + dyaw_q;
		end
		if (state_q == S_WRAP) begin
			wq_q <= qprod[35:27];
		end
		if (state_q == S_PITCH) begin
			negq_q <= (yaw_q < Deg270) && (yaw_q > Deg90);
		end
		if (state_q == S_CYAW && crsp.done) begin
			sy_q <= sgnsin;
			cy_q <= sgncos;
		end
		if (state_q == S_CPIT && crsp.done) begin
			cy_q <= cy_q;
			sy_q <= crsp.cos_q14;
			negq_q <= 1'b0;
		end
		if (state_q == S_MOVE) begin
			k_q <= k_q + 1'b1;
		end
	end

	assign done = (state_q == S_DONE);
	assign rsp.pos_x = pos_q[0];
	assign rsp.pos_y = pos_q[1];
	assign rsp.pos_z = pos_q[2];
	assign rsp.dir_x = front_q[0];
	assign rsp.dir_y = front_q[1];
	assign rsp.dir_z = front_q[2];
	assign rsp.yaw_out = yaw_q[24:0];
	assign rsp.pitch_out = pitch_q[23:0];
endmodule

// File: src/yaw_pitch_camera_controller_top.sv
// Top level of the yaw and pitch camera controller.
// How long a request takes depends on its command: a mouse move runs the one shared
// CORDIC unit twice, for yaw and for pitch, a strafe runs it once, and a forward or
// backward step or an unknown command does not use it; the CORDIC unit rotates one
// step per cycle. The block takes no request while one is in flight, and a result
// waits in an output register until taken; the next request is accepted in the cycle
// after the result is taken at the earliest.
`include "assert_macros.svh"
module yaw_pitch_camera_controller_top #(
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ypc_pkg::req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output ypc_pkg::rsp_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	import ypc_pkg::*;

	logic busy_q;
	logic [23:0] speed_q;
	logic [15:0] sens_q;
	logic [22:0] limit_q;
	logic done;
	rsp_t rsp;
	logic start;

	assign in_stall = busy_q;
	assign start = in_valid && !busy_q;
	assign cfg_ready = 1'b1;

	ypc_core #(.CordicSteps(CORDIC_STEPS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(start), .req(in_data),
		.move_speed(speed_q), .look_sensitivity(sens_q), .pitch_limit(limit_q),
		.done(done), .rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid <= 1'b0;
			speed_q <= 24'd196608;
			sens_q <= 16'd6554;
			limit_q <= 23'd5832704;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end
			if (done) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
				busy_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SPEED: speed_q <= cfg_data[23:0];
					REG_SENS: sens_q <= cfg_data[15:0];
					REG_LIMIT: limit_q <= cfg_data[22:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data <= rsp;
		end
	end

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid |-> in_stall)
	`ASSERT_IMPL(a_done_busy, clk, arst_n, done |-> busy_q)
	`ASSERT_IMPL(a_start_idle, clk, arst_n, start |=> busy_q)
endmodule

// File: test/yaw_pitch_camera_controller_top_test.sv
// Self-checking testbench of the yaw and pitch camera controller: predicts camera state and compares every result.
module yaw_pitch_camera_controller_top_test;
	import ypc_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam longint DEG360 = 23592960;
	localparam longint DEG270 = 17694720;
	localparam longint DEG180 = 11796480;
	localparam longint DEG90 = 5898240;
	localparam longint D2R = 74961321;
	localparam longint GAIN = 652032874;
	localparam longint LIMIT_CYCLES = 2000000;

	class camera_scoreboard;
		longint speed, sens, limit;
		longint pos[3];
		longint yaw, pitch;
		longint front[3];
		longint last_px, last_py;
		bit first_move;
		rsp_t pending[$];
		int errors;
		int checked;

		function new();
			speed = 196608;
			sens = 6554;
			limit = 5832704;
			pos[0] = 0;
			pos[1] = 0;
			pos[2] = 196608;
			yaw = DEG270;
			pitch = 0;
			front[0] = 0;
			front[1] = 0;
			front[2] = -16384;
			first_move = 1;
			errors = 0;
			checked = 0;
		endfunction

		function longint round_off(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint unit(longint v);
			if (v > 16384) return 16384;
			if (v < -16384) return -16384;
			return v;
		endfunction

		function void sincos(longint deg, output longint s, output longint c);
			longint z, x, y, dx, dy;
			z = round_off(deg * D2R, 18);
			x = GAIN;
			y = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= atan_q30(5'(i));
				end else begin
					x += dx;
					y -= dy;
					z += atan_q30(5'(i));
				end
			end
			s = unit(round_off(y, 16));
			c = unit(round_off(x, 16));
		endfunction

		function void sincos_heading(longint a, output longint s, output longint c);
			if (a >= DEG270) begin
				sincos(a - DEG360, s, c);
			end else if (a > DEG90) begin
				sincos(a - DEG180, s, c);
				s = -s;
				c = -c;
			end else begin
				sincos(a, s, c);
			end
		endfunction

		function void shift_position(longint dir[3], longint scale, bit negate);
			longint d, r;
			for (int k = 0; k < 3; k++) begin
				d = round_off(scale * dir[k], 14);
				r = pos[k] + (negate ? -d : d);
				if (r > 64'sd2147483647) r = 64'sd2147483647;
				if (r < -64'sd2147483648) r = -64'sd2147483648;
				pos[k] = r;
			end
		endfunction

		function void note_request(req_t rq);
			longint scale, xo, yo, lim, p, sy, cy, sp, cp;
			longint right[3];
			rsp_t r;
			scale = round_off(longint'(rq.time_step) * speed, 16);
			case (rq.command)
				CMD_MOUSE: begin
					if (first_move) begin
						last_px = rq.pointer_x;
						last_py = rq.pointer_y;
						first_move = 0;
					end
					xo = longint'(rq.pointer_x) - last_px;
					yo = last_py - longint'(rq.pointer_y);
					last_px = rq.pointer_x;
					last_py = rq.pointer_y;
					yaw = (yaw + round_off(xo * sens, 16)) % DEG360;
					if (yaw < 0) yaw += DEG360;
					lim = limit > DEG90 ? DEG90 : limit;
					p = pitch + round_off(yo * sens, 16);
					if (p > lim) p = lim;
					if (p < -lim) p = -lim;
					pitch = p;
					sincos_heading(yaw, sy, cy);
					sincos(pitch, sp, cp);
					front[0] = unit(round_off(cy * cp, 14));
					front[1] = sp;
					front[2] = unit(round_off(sy * cp, 14));
				end
				CMD_FWD, CMD_BACK: begin
					shift_position(front, scale, rq.command == CMD_BACK);
				end
				CMD_RIGHT, CMD_LEFT: begin
					sincos_heading(yaw, sy, cy);
					right[0] = -sy;
					right[1] = 0;
					right[2] = cy;
					shift_position(right, scale, rq.command == CMD_LEFT);
				end
				default: ;
			endcase
			r.pos_x = 32'(pos[0]);
			r.pos_y = 32'(pos[1]);
			r.pos_z = 32'(pos[2]);
			r.dir_x = 16'(front[0]);
			r.dir_y = 16'(front[1]);
			r.dir_z = 16'(front[2]);
			r.yaw_out = 25'(yaw);
			r.pitch_out = 24'(pitch);
			pending.push_back(r);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
			errors++;
		endtask

		task check_result(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				report("unexpected result", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (got.pos_x !== e.pos_x) report("pos_x", got.pos_x, e.pos_x);
			if (got.pos_y !== e.pos_y) report("pos_y", got.pos_y, e.pos_y);
			if (got.pos_z !== e.pos_z) report("pos_z", got.pos_z, e.pos_z);
			if (got.dir_x !== e.dir_x) report("dir_x", got.dir_x, e.dir_x);
			if (got.dir_y !== e.dir_y) report("dir_y", got.dir_y, e.dir_y);
			if (got.dir_z !== e.dir_z) report("dir_z", got.dir_z, e.dir_z);
			if (got.yaw_out !== e.yaw_out) report("yaw_out", got.yaw_out, e.yaw_out);
			if (got.pitch_out !== e.pitch_out) report("pitch_out", got.pitch_out, e.pitch_out);
			checked++;
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	rsp_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	camera_scoreboard board = new();
	longint cycles = 0;
	int sent = 0;
	int pos_px, pos_py;

	yaw_pitch_camera_controller_top #(.CORDIC_STEPS(CORDIC_STEPS)) dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("** yaw_pitch_camera_controller_top: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(out_data);
	end

	int stall_left = 0;
	bit calm = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else if (calm || stall_left == 0) begin
			out_stall <= 0;
			if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_length();
		end else begin
			out_stall <= 1;
			stall_left--;
		end
	end

	task send(req_t rq);
		in_valid <= 1;
		in_data <= rq;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_request(rq);
		sent++;
	endtask

	task send_gapped(req_t rq);
		int g;
		g = calm ? 0 : gap_length();
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		send(rq);
	endtask

	task drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			REG_SPEED: board.speed = value & 32'hFFFFFF;
			REG_SENS: board.sens = value & 32'hFFFF;
			REG_LIMIT: board.limit = value & 32'h7FFFFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function req_t make(logic [2:0] cmd, logic [31:0] px, logic [31:0] py, logic [19:0] ts);
		req_t r;
		r.command = cmd;
		r.pointer_x = px;
		r.pointer_y = py;
		r.time_step = ts;
		return r;
	endfunction

	function req_t random_request();
		int k;
		logic [2:0] cmd;
		logic [19:0] ts;
		k = $urandom_range(0, 99);
		if (k < 40) begin
			cmd = CMD_MOUSE;
		end else if (k < 96) begin
			cmd = 3'($urandom_range(CMD_FWD, CMD_LEFT));
		end else begin
			cmd = 3'($urandom_range(5, 7));
		end
		if ($urandom_range(0, 9) == 0) begin
			pos_px = $urandom;
			pos_py = $urandom;
		end else begin
			pos_px += $signed($urandom_range(0, 2000000)) - 1000000;
			pos_py += $signed($urandom_range(0, 2000000)) - 1000000;
		end
		ts = ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 20000));
		return make(cmd, pos_px, pos_py, ts);
	endfunction

	task random_phase(int n);
		for (int i = 0; i < n; i++) send_gapped(random_request());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Movement before any mouse move uses the reset heading.
		send(make(CMD_FWD, 0, 0, 20'h10000));
		send(make(CMD_RIGHT, 0, 0, 20'h08000));
		send(make(CMD_LEFT, 0, 0, 20'h0));
		send(make(3'd5, 32'h7FFFFFFF, 32'h80000000, 20'hFFFFF));
		send(make(3'd7, 0, 0, 0));
		// The first mouse move only latches the pointer.
		send(make(CMD_MOUSE, 32'h7FFFFFFF, 32'h80000000, 20'hFFFFF));
		send(make(CMD_MOUSE, 32'h80000000, 32'h7FFFFFFF, 0));
		send(make(CMD_MOUSE, 32'h7FFFFFFF, 32'h80000000, 0));
		send(make(CMD_BACK, 0, 0, 20'hFFFFF));
		send(make(3'd6, 0, 0, 0));
		drain();
		write_reg(REG_SPEED, 32'hFFFFFF);
		write_reg(REG_SENS, 32'hFFFF);
		write_reg(REG_LIMIT, 32'h7FFFFF);
		// Pitch limit above 90 degrees is treated as 90, and strafing still
		// follows yaw when looking straight up or down.
		send(make(CMD_MOUSE, 0, 32'h80000000, 0));
		send(make(CMD_RIGHT, 0, 0, 20'hFFFFF));
		send(make(CMD_FWD, 0, 0, 20'hFFFFF));
		send(make(CMD_FWD, 0, 0, 20'hFFFFF));
		send(make(CMD_MOUSE, 0, 32'h7FFFFFFF, 0));
		send(make(CMD_LEFT, 0, 0, 20'hFFFFF));
		send(make(CMD_BACK, 0, 0, 20'hFFFFF));
		send(make(CMD_BACK, 0, 0, 20'hFFFFF));
		drain();

		pos_px = 0;
		pos_py = 0;
		write_reg(REG_SPEED, 196608);
		write_reg(REG_SENS, 6554);
		write_reg(REG_LIMIT, 5832704);
		random_phase(350);
		drain();

		write_reg(REG_SPEED, 0);
		write_reg(REG_SENS, 0);
		write_reg(REG_LIMIT, 0);
		random_phase(100);
		drain();

		write_reg(REG_SPEED, $urandom_range(0, 24'hFFFFFF));
		write_reg(REG_SENS, $urandom_range(0, 16'hFFFF));
		write_reg(REG_LIMIT, $urandom_range(0, 5898240));
		calm = 1;
		random_phase(150);
		calm = 0;
		random_phase(250);
		drain();

		write_reg(REG_SPEED, 24'hFFFFFF);
		write_reg(REG_SENS, 16'hFFFF);
		write_reg(REG_LIMIT, 5898240);
		random_phase(380);
		drain();

		$display("Sent %0d requests over five register settings, %0d results checked.",
			sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("** yaw_pitch_camera_controller_top: PASSED **");
		end else begin
			$display("** yaw_pitch_camera_controller_top: FAILED **");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+src
src/ypc_pkg.sv
src/ypc_cordic.sv
src/ypc_core.sv
src/yaw_pitch_camera_controller_top.sv
test/yaw_pitch_camera_controller_top_test.sv
